[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must hold whenever the given condition is true.
`define ASSERT_WHEN(label, cond, prop, msg) \
    `ASSERT_CLK(label, (cond) |-> (prop), msg)

`endif

[design/kmks_pkg.sv]
// ----------------------------------------------------------------------------
// kmks_pkg
// Types, constants and helpers shared by the key matrix and knob scanner.
// ----------------------------------------------------------------------------
package kmks_pkg;

    localparam int unsigned ROW_W     = 4;
    localparam int unsigned NUM_KEYS  = 12;
    localparam int unsigned KEY_W     = 4;
    localparam int unsigned VOL_W     = 5;
    localparam int unsigned CNT_W     = 8;

    localparam logic [KEY_W-1:0] NO_KEY     = 4'd12;
    localparam logic [VOL_W-1:0] VOLUME_MAX = 5'd16;
    localparam logic [VOL_W-1:0] VOLUME_RST = 5'd12;
    localparam logic [CNT_W-1:0] OCTAVE_RST = 8'd4;

    typedef logic [1:0] phase_t;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2
    } step_t;

    typedef struct packed {
        phase_t volume;
        phase_t octave;
        phase_t one;
        phase_t zero;
    } knob_phases_t;

    typedef struct packed {
        logic [VOL_W-1:0] volume;
        logic [CNT_W-1:0] octave;
        logic [CNT_W-1:0] one;
        logic [CNT_W-1:0] zero;
    } knob_levels_t;

    // Gray phase to position along the forward sequence 0,1,3,2.
    function automatic logic [1:0] gray_pos(input phase_t p);
        logic [1:0] pos;
        unique case (p)
            2'b00:   pos = 2'd0;
            2'b01:   pos = 2'd1;
            2'b11:   pos = 2'd2;
            default: pos = 2'd3;
        endcase
        return pos;
    endfunction

    function automatic step_t quad_step(input phase_t old_p, input phase_t new_p);
        logic [1:0] d;
        step_t      s;
        d = gray_pos(new_p) - gray_pos(old_p);
        unique case (d)
            2'd1:    s = STEP_UP;
            2'd3:    s = STEP_DOWN;
            default: s = STEP_NONE;
        endcase
        return s;
    endfunction

    function automatic logic [CNT_W-1:0] wrap_count(input logic [CNT_W-1:0] c,
                                                    input step_t s);
        logic [CNT_W-1:0] r;
        unique case (s)
            STEP_UP:   r = c + 1'b1;
            STEP_DOWN: r = c - 1'b1;
            default:   r = c;
        endcase
        return r;
    endfunction

endpackage

[design/kmks_key_enc.sv]
// ----------------------------------------------------------------------------
// kmks_key_enc
// Finds the highest-numbered pressed key of the 12-key active-low matrix.
// ----------------------------------------------------------------------------
module kmks_key_enc (
    input  logic [kmks_pkg::NUM_KEYS-1:0] keys,
    output logic                          pressed,
    output logic [kmks_pkg::KEY_W-1:0]    index
);
    import kmks_pkg::*;

    always_comb
    begin
        index = NO_KEY;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (!keys[i])
            begin
                index = KEY_W'(i);
            end
        end
        pressed = (index != NO_KEY);
    end

endmodule

[design/kmks_knobs.sv]
// ----------------------------------------------------------------------------
// kmks_knobs
// Four quadrature knob decoders with their phase and count registers.
// ----------------------------------------------------------------------------
module kmks_knobs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  kmks_pkg::knob_phases_t     phases,
    output kmks_pkg::knob_levels_t     levels_next,
    output logic [kmks_pkg::CNT_W-1:0] octave_now
);
    import kmks_pkg::*;

    knob_phases_t     phases_reg;
    knob_levels_t     levels_reg;
    step_t            vol_step;
    logic [VOL_W-1:0] vol_clamped;

    always_comb
    begin
        vol_step    = quad_step(phases_reg.volume, phases.volume);
        vol_clamped = (levels_reg.volume > VOLUME_MAX) ? VOLUME_MAX : levels_reg.volume;
        levels_next.volume = vol_clamped;
        if (vol_step == STEP_UP && vol_clamped < VOLUME_MAX)
        begin
            levels_next.volume = vol_clamped + 1'b1;
        end
        else if (vol_step == STEP_DOWN && vol_clamped != '0)
        begin
            levels_next.volume = vol_clamped - 1'b1;
        end
        levels_next.octave = wrap_count(levels_reg.octave,
                                        quad_step(phases_reg.octave, phases.octave));
        levels_next.one    = wrap_count(levels_reg.one,
                                        quad_step(phases_reg.one, phases.one));
        levels_next.zero   = wrap_count(levels_reg.zero,
                                        quad_step(phases_reg.zero, phases.zero));
    end

    assign octave_now = levels_reg.octave;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phases_reg        <= '0;
            levels_reg.volume <= VOLUME_RST;
            levels_reg.octave <= OCTAVE_RST;
            levels_reg.one    <= '0;
            levels_reg.zero   <= '0;
        end
        else if (advance)
        begin
            phases_reg <= phases;
            levels_reg <= levels_next;
        end
    end

endmodule

[design/key_matrix_and_knob_scanner.sv]
// ----------------------------------------------------------------------------
// key_matrix_and_knob_scanner
// Scans 12 matrix keys and decodes four quadrature knobs, one word per scan.
// ----------------------------------------------------------------------------
// One scan word in gives one result word out. Each scan passes an input
// register and then an output register before its result appears, and a
// new scan can be taken every cycle as long as out_ready keeps up. in_ready
// follows out_ready combinationally through both stages.
// Knob state (phases, volume 0..16 saturating, octave and two wrapping
// counts) updates as a scan moves from the input to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_matrix_and_knob_scanner (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [kmks_pkg::ROW_W-1:0] row_zero,
    input  logic [kmks_pkg::ROW_W-1:0] row_one,
    input  logic [kmks_pkg::ROW_W-1:0] row_two,
    input  logic [kmks_pkg::ROW_W-1:0] row_three,
    input  logic [kmks_pkg::ROW_W-1:0] row_four,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       key_pressed,
    output logic [kmks_pkg::KEY_W-1:0] key_index,
    output logic [kmks_pkg::CNT_W-1:0] sent_octave,
    output logic [kmks_pkg::VOL_W-1:0] volume_level,
    output logic [kmks_pkg::CNT_W-1:0] octave_level,
    output logic [kmks_pkg::CNT_W-1:0] knob_one_count,
    output logic [kmks_pkg::CNT_W-1:0] knob_zero_count
);
    import kmks_pkg::*;

    logic                in_valid_reg;
    logic [NUM_KEYS-1:0] keys_reg;
    knob_phases_t        phases_reg;

    logic                out_valid_reg;
    logic                key_pressed_reg;
    logic [KEY_W-1:0]    key_index_reg;
    logic [CNT_W-1:0]    sent_octave_reg;
    knob_levels_t        levels_reg;

    logic                out_load;
    logic                advance;
    logic                enc_pressed;
    logic [KEY_W-1:0]    enc_index;
    knob_levels_t        levels_next;
    logic [CNT_W-1:0]    octave_now;

    assign out_load = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_load;
    assign in_ready = !in_valid_reg || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            keys_reg          <= {row_two, row_one, row_zero};
            phases_reg.volume <= row_three[1:0];
            phases_reg.octave <= row_three[3:2];
            phases_reg.one    <= row_four[1:0];
            phases_reg.zero   <= row_four[3:2];
        end
    end

    kmks_key_enc u_key_enc (
        .keys    (keys_reg),
        .pressed (enc_pressed),
        .index   (enc_index)
    );

    kmks_knobs u_knobs (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .phases      (phases_reg),
        .levels_next (levels_next),
        .octave_now  (octave_now)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_pressed_reg <= enc_pressed;
            key_index_reg   <= enc_index;
            sent_octave_reg <= octave_now;
            levels_reg      <= levels_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign key_pressed     = key_pressed_reg;
    assign key_index       = key_index_reg;
    assign sent_octave     = sent_octave_reg;
    assign volume_level    = levels_reg.volume;
    assign octave_level    = levels_reg.octave;
    assign knob_one_count  = levels_reg.one;
    assign knob_zero_count = levels_reg.zero;

    `ASSERT_WHEN(a_vol_range, out_valid_reg, levels_reg.volume <= VOLUME_MAX, "volume out of range")
    `ASSERT_WHEN(a_key_flag, out_valid_reg, key_pressed_reg == (key_index_reg != NO_KEY), "key flag mismatch")
    `ASSERT_CLK(a_advance_out, advance |=> out_valid_reg, "advanced word not presented")
    `ASSERT_WHEN(a_ready_free, !out_valid_reg, in_ready, "input stalled with empty output")

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for key_matrix_and_knob_scanner. Scan words go in on a
// valid/ready channel with random gaps. Each result word is checked against a
// scan predictor that tracks key priority, the volume clamp and the three
// wrapping knob counts. Test phases cover directed keys and knob moves,
// biased knob sweeps, a long output hold-off, a full drain and a no-idle burst.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import kmks_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int MAX_REPORTS     = 10;
    localparam int LATENCY         = 2;

    typedef struct packed {
        logic [ROW_W-1:0] r0;
        logic [ROW_W-1:0] r1;
        logic [ROW_W-1:0] r2;
        logic [ROW_W-1:0] r3;
        logic [ROW_W-1:0] r4;
    } scan_t;

    typedef struct packed {
        logic             pressed;
        logic [KEY_W-1:0] index;
        logic [CNT_W-1:0] sent_oct;
        logic [VOL_W-1:0] vol;
        logic [CNT_W-1:0] oct;
        logic [CNT_W-1:0] one;
        logic [CNT_W-1:0] zero;
    } scan_result_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [ROW_W-1:0] row_zero;
    logic [ROW_W-1:0] row_one;
    logic [ROW_W-1:0] row_two;
    logic [ROW_W-1:0] row_three;
    logic [ROW_W-1:0] row_four;
    logic             out_valid;
    logic             out_ready;
    logic             key_pressed;
    logic [KEY_W-1:0] key_index;
    logic [CNT_W-1:0] sent_octave;
    logic [VOL_W-1:0] volume_level;
    logic [CNT_W-1:0] octave_level;
    logic [CNT_W-1:0] knob_one_count;
    logic [CNT_W-1:0] knob_zero_count;

    scan_result_t expected_results [$];
    int           fail_count;
    int           cycle_count;
    bit           no_idle;
    bit           hold_req;

    // predicted block state
    knob_phases_t     prev_phases;
    logic [VOL_W-1:0] model_volume;
    logic [CNT_W-1:0] model_octave;
    logic [CNT_W-1:0] model_one;
    logic [CNT_W-1:0] model_zero;

    // driven knob phases: 0 volume, 1 octave, 2 knob one, 3 knob zero
    phase_t knob_drive [4];
    step_t  knob_dir   [4];

    key_matrix_and_knob_scanner dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .row_zero        (row_zero),
        .row_one         (row_one),
        .row_two         (row_two),
        .row_three       (row_three),
        .row_four        (row_four),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .key_pressed     (key_pressed),
        .key_index       (key_index),
        .sent_octave     (sent_octave),
        .volume_level    (volume_level),
        .octave_level    (octave_level),
        .knob_one_count  (knob_one_count),
        .knob_zero_count (knob_zero_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Gray phase <-> rank along 0,1,3,2; the mapping is its own inverse.
    function automatic logic [1:0] gray_rank(input logic [1:0] x);
        return {x[1], x[1] ^ x[0]};
    endfunction

    function automatic step_t knob_move(input phase_t was, input phase_t now);
        logic [1:0] d;
        d = gray_rank(now) - gray_rank(was);
        if (d == 2'd1)
            return STEP_UP;
        if (d == 2'd3)
            return STEP_DOWN;
        return STEP_NONE;
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c, input step_t s);
        return c + CNT_W'(s == STEP_UP) - CNT_W'(s == STEP_DOWN);
    endfunction

    function automatic scan_result_t predict_scan(input scan_t s);
        logic [11:0]  keys;
        scan_result_t r;
        knob_phases_t now;
        step_t        mv;
        keys    = {s.r2, s.r1, s.r0};
        r.index = NO_KEY;
        for (int i = 0; i < NUM_KEYS; i++)
            if (!keys[i])
                r.index = KEY_W'(i);
        r.pressed    = (r.index != NO_KEY);
        r.sent_oct   = model_octave;
        now.volume   = s.r3[1:0];
        now.octave   = s.r3[3:2];
        now.one      = s.r4[1:0];
        now.zero     = s.r4[3:2];
        mv = knob_move(prev_phases.volume, now.volume);
        if (model_volume > VOLUME_MAX)
            model_volume = VOLUME_MAX;
        if (mv == STEP_UP && model_volume < VOLUME_MAX)
            model_volume = model_volume + 1'b1;
        else if (mv == STEP_DOWN && model_volume != '0)
            model_volume = model_volume - 1'b1;
        model_octave = bump(model_octave, knob_move(prev_phases.octave, now.octave));
        model_one    = bump(model_one, knob_move(prev_phases.one, now.one));
        model_zero   = bump(model_zero, knob_move(prev_phases.zero, now.zero));
        prev_phases  = now;
        r.vol  = model_volume;
        r.oct  = model_octave;
        r.one  = model_one;
        r.zero = model_zero;
        return r;
    endfunction

    function automatic scan_t make_scan(input logic [11:0] keys);
        scan_t s;
        s.r0 = keys[3:0];
        s.r1 = keys[7:4];
        s.r2 = keys[11:8];
        s.r3 = {knob_drive[1], knob_drive[0]};
        s.r4 = {knob_drive[3], knob_drive[2]};
        return s;
    endfunction

    function automatic logic [11:0] random_keys();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 12'hFFF;
        if (r < 7)
            return ~(12'h001 << $urandom_range(0, NUM_KEYS - 1));
        return 12'($urandom);
    endfunction

    task automatic advance_knobs();
        int    r;
        step_t d;
        for (int k = 0; k < 4; k++)
        begin
            r = $urandom_range(0, 99);
            d = knob_dir[k];
            if (d == STEP_NONE)
                d = ($urandom_range(0, 1) == 1) ? STEP_UP : STEP_DOWN;
            if (r >= 94)
                knob_drive[k] = phase_t'($urandom_range(0, 3));
            else if (r >= 88)
                knob_drive[k] = gray_rank(gray_rank(knob_drive[k]) + 2'd2);
            else if (r >= 15)
                knob_drive[k] = gray_rank(gray_rank(knob_drive[k]) +
                                          ((d == STEP_UP) ? 2'd1 : 2'd3));
        end
    endtask

    task automatic set_all_knobs(input phase_t p);
        for (int k = 0; k < 4; k++)
            knob_drive[k] = p;
    endtask

    // Called and returns on a falling edge.
    task automatic send_scan(input scan_t s);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        row_zero  <= s.r0;
        row_one   <= s.r1;
        row_two   <= s.r2;
        row_three <= s.r3;
        row_four  <= s.r4;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(predict_scan(s));
        @(negedge clk);
    endtask

    // Called on a falling edge; the sender goes idle until all results are in.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        logic [11:0] key_list [7];
        key_list = '{12'hFFF, 12'h000, ~12'h001, ~12'h800, ~12'h010, ~12'h108, 12'hFFF};
        set_all_knobs(2'b00);
        foreach (key_list[i])
            send_scan(make_scan(key_list[i]));
        // forward then reverse around the whole cycle on all knobs
        set_all_knobs(2'b01); send_scan(make_scan(12'hFFF));
        set_all_knobs(2'b11); send_scan(make_scan(12'hFFF));
        set_all_knobs(2'b10); send_scan(make_scan(12'hFFF));
        set_all_knobs(2'b00); send_scan(make_scan(12'hFFF));
        set_all_knobs(2'b10); send_scan(make_scan(12'hFFF));
        set_all_knobs(2'b11); send_scan(make_scan(12'hFFF));
        set_all_knobs(2'b01); send_scan(make_scan(12'hFFF));
        set_all_knobs(2'b00); send_scan(make_scan(12'hFFF));
        // two-step jumps count nothing
        set_all_knobs(2'b11); send_scan(make_scan(~12'h400));
        set_all_knobs(2'b00); send_scan(make_scan(12'hFFF));
        // each knob a different move in one scan
        knob_drive = '{2'b01, 2'b10, 2'b11, 2'b00};
        send_scan(make_scan(~12'h020));
        set_all_knobs(2'b00);
        send_scan(make_scan(12'hFFF));
    endtask

    // Knobs drift in a per-segment direction so volume hits both rails.
    task automatic test_knob_sweeps(input int segments, input int per_seg);
        for (int g = 0; g < segments; g++)
        begin
            for (int k = 0; k < 4; k++)
                knob_dir[k] = step_t'($urandom_range(0, 2));
            for (int n = 0; n < per_seg; n++)
            begin
                advance_knobs();
                send_scan(make_scan(random_keys()));
            end
        end
    endtask

    task automatic test_back_pressure();
        hold_req = 1'b1;
        no_idle  = 1'b1;
        for (int n = 0; n < 24; n++)
        begin
            advance_knobs();
            send_scan(make_scan(random_keys()));
        end
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        test_knob_sweeps(1, 10);
        wait_drain();
        test_knob_sweeps(1, 10);
    endtask

    task automatic test_burst();
        no_idle = 1'b1;
        test_knob_sweeps(1, 40);
        no_idle = 1'b0;
    endtask

    initial
    begin : stimulus
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        row_zero    = '1;
        row_one     = '1;
        row_two     = '1;
        row_three   = '0;
        row_four    = '0;
        out_ready   = 1'b0;
        no_idle     = 1'b0;
        hold_req    = 1'b0;
        fail_count  = 0;
        prev_phases = '0;
        model_volume = VOLUME_RST;
        model_octave = OCTAVE_RST;
        model_one    = '0;
        model_zero   = '0;
        set_all_knobs(2'b00);
        knob_dir = '{STEP_NONE, STEP_NONE, STEP_NONE, STEP_NONE};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_knob_sweeps(5, 40);
        test_back_pressure();
        test_drain_pause();
        test_knob_sweeps(4, 40);
        test_burst();

        wait_drain();
        repeat (LATENCY + 4) @(negedge clk);
        fail_count += expected_results.size();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin : result_checker
        scan_result_t got;
        scan_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got = '{key_pressed, key_index, sent_octave, volume_level,
                        octave_level, knob_one_count, knob_zero_count};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected word: pressed %0d key %0d sent %0d vol %0d",
                                 got.pressed, got.index, got.sent_oct, got.vol);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("mismatch exp: p %0d k %0d s %0d v %0d o %0d 1:%0d 0:%0d",
                                     want.pressed, want.index, want.sent_oct, want.vol,
                                     want.oct, want.one, want.zero);
                            $display("         got: p %0d k %0d s %0d v %0d o %0d 1:%0d 0:%0d",
                                     got.pressed, got.index, got.sent_oct, got.vol,
                                     got.oct, got.one, got.zero);
                        end
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
